// ===== rtl/ttpg_pkg.sv =====
// Shared types, register indexes and the attribute coloring rule for the text pixel generator.
package ttpg_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 14;
    localparam int InDataWidth   = 56;
    localparam int OutDataWidth  = 24;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_MODE_CONTROL   = 3'd0,
        REG_ATTR_MAP       = 3'd1,
        REG_THIN_FONT      = 3'd2,
        REG_CURSOR_START   = 3'd3,
        REG_CURSOR_END     = 3'd4,
        REG_CURSOR_ADDRESS = 3'd5,
        REG_COLOUR_SELECT  = 3'd6
    } cfg_reg_t;

    localparam logic [7:0]  ModeControlReset   = 8'h00;
    localparam logic [3:0]  AttrMapReset       = 4'h4;
    localparam logic        ThinFontReset      = 1'b1;
    localparam logic [6:0]  CursorStartReset   = 7'h00;
    localparam logic [3:0]  CursorEndReset     = 4'h0;
    localparam logic [13:0] CursorAddressReset = 14'h0000;
    localparam logic [3:0]  ColourSelectReset  = 4'h0;

    localparam logic [4:0]  CountNarrow = 5'd8;
    localparam logic [4:0]  CountWide   = 5'd16;

    // Background color, foreground color and bold select of one text cell
    typedef struct packed {
        logic c0;
        logic c1;
        logic bold;
    } attr_color_t;

    function automatic attr_color_t attr_rule(input logic [7:0] n, input logic blink_mode,
                                              input logic [3:0] m);
        attr_color_t r;
        r.c0   = 1'b1;
        r.c1   = 1'b0;
        r.bold = n[3];
        // upper groups, excluding x0 and x8
        if (n >= 8'h11 && n[2:0] != 3'd0) begin
            r.c0 = m[2];
            r.c1 = ~m[2];
            if (m[3]) r.bold = 1'b1;
        end
        if (n >= 8'h01 && n <= 8'h0E && n != 8'h07) begin
            r.c0 = m[0];
            r.c1 = ~m[0];
            if (m[1]) r.bold = 1'b1;
        end
        if (blink_mode && n >= 8'h81 && n <= 8'h8E && n != 8'h87) begin
            r.c0 = m[0];
            r.c1 = ~m[0];
        end
        if (n == 8'h07 || n == 8'h0F) begin
            r.c0 = 1'b0;
            r.c1 = 1'b1;
        end
        if (blink_mode && (n == 8'h87 || n == 8'h8F)) begin
            r.c0 = 1'b0;
            r.c1 = 1'b1;
        end
        if (n >= 8'h81 && n <= 8'h8F) begin
            if (!blink_mode) begin
                r.c0 = 1'b0;
                r.c1 = 1'b1;
            end
            r.bold = n[3];
        end
        // multiples of 0x11 are solid light (in blink mode, bit 7 is ignored)
        if (!blink_mode) begin
            if (n[7:4] == n[3:0]) begin
                r.c0 = 1'b0;
                r.c1 = 1'b0;
            end
        end else begin
            if ({1'b0, n[6:4]} == n[3:0]) begin
                r.c0 = 1'b0;
                r.c1 = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/two_tone_text_pixel_generator.sv =====
// Top level of the two-tone text and graphics pixel generator.
//
// Usage: each item on the s_ channel is one character cell (code, attribute,
// both font rows, scanline, line parity, blink phase and cell address) or, in
// graphics modes, one video byte in the code field. Each item yields exactly
// one result on the m_ channel: a row of pixel bits (1 = dark ink, msb
// leftmost) and a pixel count of 16 in 40-column text, 8 otherwise.
// The accepting edge loads the input register; the item then moves to the
// result register, which raises m_tvalid, once the output side can take it.
// Throughput is one item per cycle while m_tready stays high; the coloring,
// cursor and dither logic sits between those two registers.
// Configuration registers must be written through cfg_wr_en/cfg_index/
// cfg_wdata only while no item is in flight; the block does not enforce this.
// An unknown index is ignored. Reset clears both valid flags and loads the
// register defaults (attribute map 4, thin font 1, all others 0). When the
// receiver stalls, the result register holds, the input register takes one
// more item if it is empty, then s_tready drops until m_tready returns.
module two_tone_text_pixel_generator
    import ttpg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // cell_address[13:0], char_code[21:14], attribute[29:22], font_row_normal[37:30],
    // font_row_bold[45:38], scanline[48:46], line_odd[49], blink_phase[50], zero[55:51]
    input  logic [InDataWidth-1:0]   s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // pixels[15:0], pixel_count[20:16], zero[23:21]
    output logic [OutDataWidth-1:0]  m_tdata
);

    logic [7:0]  mode_control_reg;
    logic [3:0]  attr_map_reg;
    logic        thin_font_reg;
    logic [6:0]  cursor_start_reg;
    logic [3:0]  cursor_end_reg;
    logic [13:0] cursor_address_reg;
    logic [3:0]  colour_select_reg;

    logic                   in_valid_reg;
    logic [InDataWidth-1:0] in_data_reg;
    logic                   out_valid_reg;
    logic [15:0]            pixels_reg;
    logic [4:0]             count_reg;
    logic [15:0]            pixels_next;
    logic [4:0]             count_next;
    logic                   out_ready;

    logic [13:0] cell_address;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [7:0]  font_row_normal;
    logic [7:0]  font_row_bold;
    logic [2:0]  scanline;
    logic        line_odd;
    logic        blink_phase;

    logic        blink_mode;
    logic        enabled;
    logic        cursor_line;
    logic        cursor_on;
    logic        blank;
    attr_color_t color;
    logic        fg;
    logic [7:0]  font_row;
    logic [7:0]  text_pix;
    logic [7:0]  gfx_pix;
    logic [1:0]  gfx_pair;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_control_reg   <= ModeControlReset;
            attr_map_reg       <= AttrMapReset;
            thin_font_reg      <= ThinFontReset;
            cursor_start_reg   <= CursorStartReset;
            cursor_end_reg     <= CursorEndReset;
            cursor_address_reg <= CursorAddressReset;
            colour_select_reg  <= ColourSelectReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE_CONTROL:   mode_control_reg   <= cfg_wdata[7:0];
                REG_ATTR_MAP:       attr_map_reg       <= cfg_wdata[3:0];
                REG_THIN_FONT:      thin_font_reg      <= cfg_wdata[0];
                REG_CURSOR_START:   cursor_start_reg   <= cfg_wdata[6:0];
                REG_CURSOR_END:     cursor_end_reg     <= cfg_wdata[3:0];
                REG_CURSOR_ADDRESS: cursor_address_reg <= cfg_wdata[13:0];
                REG_COLOUR_SELECT:  colour_select_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (out_ready) out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_data_reg <= s_tdata;
        if (in_valid_reg && out_ready) begin
            pixels_reg <= pixels_next;
            count_reg  <= count_next;
        end
    end

    assign cell_address    = in_data_reg[13:0];
    assign char_code       = in_data_reg[21:14];
    assign attribute       = in_data_reg[29:22];
    assign font_row_normal = in_data_reg[37:30];
    assign font_row_bold   = in_data_reg[45:38];
    assign scanline        = in_data_reg[48:46];
    assign line_odd        = in_data_reg[49];
    assign blink_phase     = in_data_reg[50];

    // text cell coloring and cursor
    always_comb begin
        blink_mode  = mode_control_reg[5];
        enabled     = mode_control_reg[3];
        cursor_line = (cursor_start_reg[6:5] != 2'b01)
                      && (cursor_start_reg[3:0] <= {1'b0, scanline})
                      && (cursor_end_reg >= {1'b0, scanline});
        cursor_on   = (cell_address == cursor_address_reg) && cursor_line
                      && enabled && blink_phase;
        blank       = blink_phase && blink_mode && attribute[7] && !cursor_on;
        color       = attr_rule(attribute, blink_mode, attr_map_reg);
        fg          = blank ? color.c0 : color.c1;
        font_row    = (color.bold ^ thin_font_reg) ? font_row_bold : font_row_normal;
        text_pix    = ((font_row & {8{fg}}) | (~font_row & {8{color.c0}}))
                      ^ {8{cursor_on}};
    end

    // graphics byte: 1 bpp with ink select, or 2 bpp dither on line parity
    always_comb begin
        gfx_pix  = '0;
        gfx_pair = '0;
        if (mode_control_reg[4]) begin
            gfx_pix = (enabled && colour_select_reg != 4'd0) ? char_code : 8'd0;
        end else begin
            for (int i = 0; i < 4; i++) begin
                gfx_pair = enabled ? char_code[2*i +: 2] : 2'b00;
                case (gfx_pair)
                    2'b00:   gfx_pix[2*i +: 2] = 2'b00;
                    2'b01:   gfx_pix[2*i +: 2] = line_odd ? 2'b00 : 2'b10;
                    2'b10:   gfx_pix[2*i +: 2] = line_odd ? 2'b01 : 2'b10;
                    default: gfx_pix[2*i +: 2] = 2'b11;
                endcase
            end
        end
    end

    always_comb begin
        pixels_next = '0;
        count_next  = CountNarrow;
        if (mode_control_reg[1]) begin
            pixels_next = {8'd0, gfx_pix};
        end else if (mode_control_reg[0]) begin
            pixels_next = {8'd0, text_pix};
        end else begin
            for (int i = 0; i < 8; i++) begin
                pixels_next[2*i +: 2] = {2{text_pix[i]}};
            end
            count_next = CountWide;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, count_reg, pixels_reg};

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=> m_tvalid)
        else $error("held item did not advance to the result register");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count_reg == CountNarrow || count_reg == CountWide))
        else $error("pixel count is neither 8 nor 16");

    a_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && count_reg == CountNarrow |-> pixels_reg[15:8] == 8'd0)
        else $error("eight-pixel result has upper bits set");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the two-tone text and graphics pixel generator.
module tb_top;
    import ttpg_pkg::*;

    localparam int IdleLimit = 2000;

    typedef struct packed {
        logic [13:0] cell_address;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [7:0]  font_row_normal;
        logic [7:0]  font_row_bold;
        logic [2:0]  scanline;
        logic        line_odd;
        logic        blink_phase;
    } cell_t;

    typedef struct packed {
        logic [4:0]  pixel_count;
        logic [15:0] pixels;
    } row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = REG_MODE_CONTROL;
    logic [CfgDataWidth-1:0]  cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [InDataWidth-1:0]   s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OutDataWidth-1:0]  m_tdata;

    logic [7:0]  mode_reg   = ModeControlReset;
    logic [3:0]  amap_reg   = AttrMapReset;
    logic        thin_reg   = ThinFontReset;
    logic [6:0]  cstart_reg = CursorStartReset;
    logic [3:0]  cend_reg   = CursorEndReset;
    logic [13:0] caddr_reg  = CursorAddressReset;
    logic [3:0]  csel_reg   = ColourSelectReset;

    row_t expected_rows[$];
    row_t got_row;
    row_t want_row;
    int   fail_count  = 0;
    int   idle_cycles = 0;
    int   stall_left  = 0;
    bit   no_idle     = 1'b0;

    two_tone_text_pixel_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void cell_colors(input logic [7:0] n, input logic blink,
                                        output logic bg, output logic fg, output logic bd);
        int v;
        bg = 1'b1;
        fg = 1'b0;
        bd = n[3];
        if (n >= 8'h11 && n[2:0] != 3'd0) begin
            bg = amap_reg[2];
            fg = !amap_reg[2];
            if (amap_reg[3]) bd = 1'b1;
        end
        if (n >= 8'h01 && n <= 8'h0E && n != 8'h07) begin
            bg = amap_reg[0];
            fg = !amap_reg[0];
            if (amap_reg[1]) bd = 1'b1;
        end
        if (blink && n >= 8'h81 && n <= 8'h8E && n != 8'h87) begin
            bg = amap_reg[0];
            fg = !amap_reg[0];
        end
        if (n == 8'h07 || n == 8'h0F || (blink && (n == 8'h87 || n == 8'h8F))) begin
            bg = 1'b0;
            fg = 1'b1;
        end
        if (n >= 8'h81 && n <= 8'h8F) begin
            if (!blink) begin
                bg = 1'b0;
                fg = 1'b1;
            end
            bd = n[3];
        end
        v = blink ? int'(n[6:0]) : int'(n);
        if (v % 17 == 0) begin
            bg = 1'b0;
            fg = 1'b0;
        end
    endfunction

    function automatic logic [7:0] text_pixels(input cell_t c);
        logic       blink;
        logic       on_line;
        logic       cursor_on;
        logic       bg;
        logic       fg;
        logic       bd;
        logic [7:0] font;
        logic [7:0] out;
        blink = mode_reg[5];
        on_line = (cstart_reg[6:5] == 2'b01) ? 1'b0 :
                  (cstart_reg[3:0] <= {1'b0, c.scanline} && cend_reg >= {1'b0, c.scanline});
        cursor_on = (c.cell_address == caddr_reg) && on_line && mode_reg[3] && c.blink_phase;
        cell_colors(c.attribute, blink, bg, fg, bd);
        if (c.blink_phase && blink && c.attribute[7] && !cursor_on) fg = bg;
        font = (bd ^ thin_reg) ? c.font_row_bold : c.font_row_normal;
        out = (font & {8{fg}}) | (~font & {8{bg}});
        return out ^ {8{cursor_on}};
    endfunction

    function automatic row_t predict_row(input cell_t c);
        row_t       r;
        logic [1:0] p;
        logic [1:0] two;
        logic [7:0] t;
        r.pixels = '0;
        r.pixel_count = CountNarrow;
        if (mode_reg[1]) begin
            if (mode_reg[4]) begin
                r.pixels[7:0] = (mode_reg[3] && csel_reg != 4'd0) ? c.char_code : 8'h00;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    p = mode_reg[3] ? c.char_code[2*i +: 2] : 2'b00;
                    case (p)
                        2'd0: two = 2'd0;
                        2'd1: two = c.line_odd ? 2'd0 : 2'd2;
                        2'd2: two = c.line_odd ? 2'd1 : 2'd2;
                        default: two = 2'd3;
                    endcase
                    r.pixels[2*i +: 2] = two;
                end
            end
        end else if (mode_reg[0]) begin
            r.pixels[7:0] = text_pixels(c);
        end else begin
            t = text_pixels(c);
            for (int i = 0; i < 8; i++) r.pixels[2*i +: 2] = {2{t[i]}};
            r.pixel_count = CountWide;
        end
        return r;
    endfunction

    function automatic cell_t make_cell(input int addr, input int code, input int attr,
                                        input int fn, input int fb, input int scan,
                                        input int odd, input int ph);
        cell_t c;
        c.cell_address    = addr[13:0];
        c.char_code       = code[7:0];
        c.attribute       = attr[7:0];
        c.font_row_normal = fn[7:0];
        c.font_row_bold   = fb[7:0];
        c.scanline        = scan[2:0];
        c.line_odd        = odd[0];
        c.blink_phase     = ph[0];
        return c;
    endfunction

    function automatic cell_t rand_cell();
        byte unsigned special_attrs[23] = '{8'h00, 8'h01, 8'h06, 8'h07, 8'h08, 8'h0E, 8'h0F,
                                            8'h10, 8'h11, 8'h17, 8'h18, 8'h77, 8'h80, 8'h81,
                                            8'h86, 8'h87, 8'h88, 8'h8E, 8'h8F, 8'h90, 8'h91,
                                            8'hF8, 8'hFF};
        int attr;
        int addr;
        attr = ($urandom_range(0, 9) < 3) ? special_attrs[$urandom_range(0, 22)]
                                          : $urandom_range(0, 255);
        addr = ($urandom_range(0, 9) < 3) ? int'(caddr_reg) : $urandom_range(0, 16383);
        return make_cell(addr, $urandom_range(0, 255), attr, $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 1),
                         $urandom_range(0, 1));
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_value(input int hi);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    task automatic send_cell(input cell_t c);
        logic ready_seen;
        int   gap;
        s_tdata <= {5'd0, c.blink_phase, c.line_odd, c.scanline, c.font_row_bold,
                    c.font_row_normal, c.attribute, c.char_code, c.cell_address};
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        expected_rows.push_back(predict_row(c));
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic hold_until_empty();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_rows.size() != 0);
    endtask

    task automatic drain();
        hold_until_empty();
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[13:0];
        @(posedge aclk);
        case (idx)
            REG_MODE_CONTROL:   mode_reg   = val[7:0];
            REG_ATTR_MAP:       amap_reg   = val[3:0];
            REG_THIN_FONT:      thin_reg   = val[0];
            REG_CURSOR_START:   cstart_reg = val[6:0];
            REG_CURSOR_END:     cend_reg   = val[3:0];
            REG_CURSOR_ADDRESS: caddr_reg  = val[13:0];
            REG_COLOUR_SELECT:  csel_reg   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int mode, input int amap, input int thin, input int cstart,
                              input int cend, input int caddr, input int csel);
        cfg_write(REG_MODE_CONTROL, mode);
        cfg_write(REG_ATTR_MAP, amap);
        cfg_write(REG_THIN_FONT, thin);
        cfg_write(REG_CURSOR_START, cstart);
        cfg_write(REG_CURSOR_END, cend);
        cfg_write(REG_CURSOR_ADDRESS, caddr);
        cfg_write(REG_COLOUR_SELECT, csel);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_state();
        send_cell(make_cell(0, 8'h41, 8'h01, 8'hA5, 8'h3C, 0, 0, 1));
        send_cell(make_cell(16383, 8'hFF, 8'h07, 8'h81, 8'h7E, 7, 1, 0));
    endtask

    task automatic test_attribute_rules();
        byte unsigned plain_attrs[11] = '{8'h00, 8'h01, 8'h07, 8'h08, 8'h0F, 8'h11, 8'h77,
                                          8'h81, 8'h87, 8'h8F, 8'hFF};
        byte unsigned blink_attrs[5] = '{8'h81, 8'h87, 8'h8E, 8'h8F, 8'hF7};
        drain();
        set_config(8'h01, 4'h0, 0, 0, 0, 0, 0);
        foreach (plain_attrs[i])
            send_cell(make_cell(100, i, plain_attrs[i], 8'hC3, 8'h5A, i % 8, 0, 1));
        drain();
        set_config(8'h21, 4'hF, 1, 0, 0, 0, 0);
        foreach (blink_attrs[i])
            send_cell(make_cell(100, i, blink_attrs[i], 8'hF0, 8'h0F, i, 1, 1));
    endtask

    task automatic test_cursor();
        drain();
        set_config(8'h09, 4'h4, 0, 2, 5, 16383, 0);
        send_cell(make_cell(16383, 0, 8'h07, 8'h18, 8'h24, 1, 0, 1));
        send_cell(make_cell(16383, 0, 8'h07, 8'h18, 8'h24, 2, 0, 1));
        send_cell(make_cell(16383, 0, 8'h87, 8'h18, 8'h24, 5, 0, 1));
        drain();
        set_config(8'h29, 4'h4, 0, 8'h22, 15, 16383, 0);
        send_cell(make_cell(16383, 0, 8'h87, 8'h18, 8'h24, 3, 0, 1));
    endtask

    task automatic test_graphics();
        drain();
        set_config(8'h0A, 4'h4, 1, 0, 0, 0, 0);
        send_cell(make_cell(0, 8'hE4, 0, 0, 0, 0, 0, 0));
        send_cell(make_cell(0, 8'hE4, 0, 0, 0, 0, 1, 0));
        drain();
        set_config(8'h1A, 4'h4, 1, 0, 0, 0, 15);
        send_cell(make_cell(0, 8'hA5, 0, 0, 0, 0, 0, 0));
        drain();
        set_config(8'h02, 4'h4, 1, 0, 0, 0, 15);
        send_cell(make_cell(0, 8'hFF, 0, 0, 0, 0, 1, 0));
    endtask

    task automatic test_random_cells();
        int mode;
        for (int phase = 0; phase < 12; phase++) begin
            drain();
            if (phase == 0) begin
                set_config(0, 0, 0, 0, 0, 0, 0);
            end else if (phase == 1) begin
                set_config(255, 15, 1, 127, 15, 16383, 15);
            end else begin
                mode = $urandom_range(0, 255);
                if ($urandom_range(0, 1) == 0) mode = mode & 8'hFD;
                set_config(mode, pick_value(15), $urandom_range(0, 1), pick_value(127),
                           pick_value(15), pick_value(16383), pick_value(15));
            end
            no_idle = (phase % 4 == 3);
            for (int i = 0; i < 72; i++) begin
                if ((phase == 2 && i == 36) || $urandom_range(0, 79) == 0) hold_until_empty();
                send_cell(rand_cell());
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 4) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got_row.pixels      = m_tdata[15:0];
            got_row.pixel_count = m_tdata[20:16];
            if (expected_rows.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected item: pixels=%h count=%0d",
                             got_row.pixels, got_row.pixel_count);
            end else begin
                want_row = expected_rows.pop_front();
                if (got_row.pixels !== want_row.pixels ||
                    got_row.pixel_count !== want_row.pixel_count) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected pixels=%h count=%0d, got pixels=%h count=%0d",
                                 want_row.pixels, want_row.pixel_count,
                                 got_row.pixels, got_row.pixel_count);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_attribute_rules();
        test_cursor();
        test_graphics();
        test_random_cells();
        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_rows.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
